>>> rtl/mse_pkg.sv
// Shared types, scancode constants and opcode codes for the modifier
// scancode emitter. No dependencies; every other file imports this package.
package mse_pkg;

    // Opcodes of an input item.
    localparam logic [3:0] OP_KEY          = 4'd0;
    localparam logic [3:0] OP_ALT          = 4'd1;
    localparam logic [3:0] OP_STICKY_ALT   = 4'd2;
    localparam logic [3:0] OP_SHIFT        = 4'd3;
    localparam logic [3:0] OP_STICKY_SHIFT = 4'd4;
    localparam logic [3:0] OP_CTRL         = 4'd5;
    localparam logic [3:0] OP_STICKY_CTRL  = 4'd6;
    localparam logic [3:0] OP_RESET        = 4'd7;
    localparam logic [3:0] OP_HELP         = 4'd8;

    // Scancode bytes.
    localparam logic [7:0] SC_SHIFT = 8'h2A;
    localparam logic [7:0] SC_CTRL  = 8'h1D;
    localparam logic [7:0] SC_ALT   = 8'h38;
    localparam logic [7:0] SC_EXT   = 8'hE0;
    localparam logic [7:0] SC_BREAK = 8'h80;

    // Modifier positions in the one-shot and sticky flag vectors.
    localparam int unsigned MOD_SHIFT = 0;
    localparam int unsigned MOD_CTRL  = 1;
    localparam int unsigned MOD_ALT   = 2;
    localparam int unsigned NUM_MODS  = 3;

    // Byte slots of one job, sent lowest first.
    localparam int unsigned NUM_SLOTS = 9;
    localparam int unsigned SLOT_SCAN = 4;

    // Default depth of the job queue between front and back.
    localparam int unsigned JOB_DEPTH_DEFAULT = 2;

    typedef struct packed {
        logic [3:0] opcode;
        logic [7:0] key_scan;
        logic [7:0] key_ascii;
        logic       want_shift;
        logic       want_ctrl;
        logic       want_alt;
    } t_in_item;

    typedef struct packed {
        logic [7:0] scan_byte;
        logic       last_byte;
    } t_out_item;

    // One job: which byte slots are to be sent, and how slots map to bytes.
    // In key order the slots are shift/ctrl/alt make, E0, scan, scan break,
    // shift/ctrl/alt break. In release order slots 0 to 2 are ctrl, shift
    // and alt break. A single byte travels in the scan slot.
    typedef struct packed {
        logic                 rel_order;
        logic [NUM_SLOTS-1:0] slots;
        logic [7:0]           scan;
    } t_job;

    typedef struct packed {
        logic valid;
        t_job job;
    } t_job_req;

endpackage

>>> rtl/mse_front.sv
// Front part: decodes an accepted item, keeps the modifier and help flags,
// and turns the item into a byte job. Depends on mse_pkg.
module mse_front (
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  logic              i_accept,
    input  mse_pkg::t_in_item i_item,
    output mse_pkg::t_job_req o_job_req
);
    import mse_pkg::*;

    logic [NUM_MODS-1:0] r_one_shot, n_one_shot;
    logic [NUM_MODS-1:0] r_sticky, n_sticky;
    logic                r_help, n_help;

    logic [NUM_MODS-1:0] want;
    logic [NUM_MODS-1:0] wrap;
    logic                op_valid;
    logic                cmd;
    logic [1:0]          cmd_mod;
    logic                cmd_sticky;
    logic [7:0]          cmd_code;

    assign want     = {i_item.want_alt, i_item.want_ctrl, i_item.want_shift};
    assign wrap     = (want | r_one_shot) & ~r_sticky;
    assign op_valid = i_item.opcode inside {[OP_KEY:OP_HELP]};

    // Make code of the modifier that a command names.
    always_comb begin
        case (cmd_mod)
            2'(MOD_SHIFT): cmd_code = SC_SHIFT;
            2'(MOD_CTRL):  cmd_code = SC_CTRL;
            2'(MOD_ALT):   cmd_code = SC_ALT;
            default:       cmd_code = SC_SHIFT;
        endcase
    end

    // Decode the item, work out the next flags and the job.
    always_comb begin
        n_one_shot = r_one_shot;
        n_sticky   = r_sticky;
        n_help     = r_help;
        o_job_req  = '0;
        cmd        = 1'b0;
        cmd_mod    = 2'(MOD_SHIFT);
        cmd_sticky = 1'b0;

        if (i_accept && op_valid) begin
            if (r_help) begin
                // The event after help is swallowed.
                n_help = 1'b0;
            end else begin
                case (i_item.opcode)
                    OP_KEY: begin
                        o_job_req.valid         = 1'b1;
                        o_job_req.job.rel_order = 1'b0;
                        o_job_req.job.slots     = {wrap, 2'b11,
                                                   i_item.key_ascii == SC_EXT, wrap};
                        o_job_req.job.scan      = i_item.key_scan;
                        n_one_shot              = r_one_shot & ~wrap;
                    end
                    OP_ALT: begin
                        cmd     = 1'b1;
                        cmd_mod = 2'(MOD_ALT);
                    end
                    OP_STICKY_ALT: begin
                        cmd        = 1'b1;
                        cmd_mod    = 2'(MOD_ALT);
                        cmd_sticky = 1'b1;
                    end
                    OP_SHIFT: begin
                        cmd     = 1'b1;
                        cmd_mod = 2'(MOD_SHIFT);
                    end
                    OP_STICKY_SHIFT: begin
                        cmd        = 1'b1;
                        cmd_mod    = 2'(MOD_SHIFT);
                        cmd_sticky = 1'b1;
                    end
                    OP_CTRL: begin
                        cmd     = 1'b1;
                        cmd_mod = 2'(MOD_CTRL);
                    end
                    OP_STICKY_CTRL: begin
                        cmd        = 1'b1;
                        cmd_mod    = 2'(MOD_CTRL);
                        cmd_sticky = 1'b1;
                    end
                    OP_RESET: begin
                        o_job_req.valid         = |r_sticky;
                        o_job_req.job.rel_order = 1'b1;
                        o_job_req.job.slots     = {6'b0, r_sticky[MOD_ALT],
                                                   r_sticky[MOD_SHIFT], r_sticky[MOD_CTRL]};
                        o_job_req.job.scan      = '0;
                        n_one_shot              = '0;
                        n_sticky                = '0;
                    end
                    OP_HELP: begin
                        n_help = 1'b1;
                    end
                    default: begin
                    end
                endcase

                // Modifier commands: release a sticky modifier, latch a sticky
                // one, or arm the one-shot flag.
                if (cmd) begin
                    if (r_sticky[cmd_mod]) begin
                        n_sticky[cmd_mod]               = 1'b0;
                        o_job_req.valid                 = 1'b1;
                        o_job_req.job.slots[SLOT_SCAN]  = 1'b1;
                        o_job_req.job.scan              = cmd_code | SC_BREAK;
                    end else if (cmd_sticky) begin
                        n_sticky[cmd_mod]               = 1'b1;
                        o_job_req.valid                 = 1'b1;
                        o_job_req.job.slots[SLOT_SCAN]  = 1'b1;
                        o_job_req.job.scan              = cmd_code;
                    end else begin
                        n_one_shot[cmd_mod] = 1'b1;
                    end
                end
            end
        end
    end

    // Flag registers.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_one_shot <= '0;
            r_sticky   <= '0;
            r_help     <= 1'b0;
        end else begin
            r_one_shot <= n_one_shot;
            r_sticky   <= n_sticky;
            r_help     <= n_help;
        end
    end

endmodule

>>> rtl/mse_job_queue.sv
// Short register queue of byte jobs between the front and the back part.
// Depends on mse_pkg.
module mse_job_queue #(
    parameter int unsigned DEPTH = mse_pkg::JOB_DEPTH_DEFAULT
) (
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  mse_pkg::t_job_req i_push_req,
    input  logic              i_pop,
    output logic              o_full,
    output logic              o_valid,
    output mse_pkg::t_job     o_job
);
    import mse_pkg::*;

    localparam int unsigned PTR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
    localparam int unsigned CNT_W = $clog2(DEPTH + 1);
    localparam logic [PTR_W-1:0] LAST_PTR = PTR_W'(DEPTH - 1);

    t_job             r_mem [DEPTH];
    logic [PTR_W-1:0] r_wr_ptr, n_wr_ptr;
    logic [PTR_W-1:0] r_rd_ptr, n_rd_ptr;
    logic [CNT_W-1:0] r_count, n_count;
    logic             do_push, do_pop;

    assign o_full  = r_count == CNT_W'(DEPTH);
    assign o_valid = r_count != '0;
    assign o_job   = r_mem[r_rd_ptr];
    assign do_push = i_push_req.valid && !o_full;
    assign do_pop  = i_pop && o_valid;

    // Pointer and count update, wrapping at the queue depth.
    always_comb begin
        n_wr_ptr = r_wr_ptr;
        n_rd_ptr = r_rd_ptr;
        n_count  = r_count;
        if (do_push) begin
            n_wr_ptr = (r_wr_ptr == LAST_PTR) ? '0 : r_wr_ptr + PTR_W'(1);
        end
        if (do_pop) begin
            n_rd_ptr = (r_rd_ptr == LAST_PTR) ? '0 : r_rd_ptr + PTR_W'(1);
        end
        case ({do_push, do_pop})
            2'b10:   n_count = r_count + CNT_W'(1);
            2'b01:   n_count = r_count - CNT_W'(1);
            default: n_count = r_count;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wr_ptr <= '0;
            r_rd_ptr <= '0;
            r_count  <= '0;
        end else begin
            r_wr_ptr <= n_wr_ptr;
            r_rd_ptr <= n_rd_ptr;
            r_count  <= n_count;
        end
    end

    // Job storage needs no reset.
    always_ff @(posedge i_clk) begin
        if (do_push) begin
            r_mem[r_wr_ptr] <= i_push_req.job;
        end
    end

endmodule

>>> rtl/mse_back.sv
// Back part: walks the byte slots of one job at a time and sends one
// scancode byte per cycle into the result register while that register is free or popped. Depends on mse_pkg.
module mse_back (
    input  logic               i_clk,
    input  logic               i_rst_n,
    input  logic               i_job_valid,
    input  mse_pkg::t_job      i_job,
    output logic               o_job_pop,
    input  logic               i_pop,
    output logic               o_empty,
    output mse_pkg::t_out_item o_result
);
    import mse_pkg::*;

    logic [NUM_SLOTS-1:0] r_mask;
    logic                 r_rel_order;
    logic [7:0]           r_scan;
    logic                 r_out_valid;
    t_out_item            r_out;

    logic [7:0]           slot_byte [NUM_SLOTS];
    logic [NUM_SLOTS-1:0] low_bit;
    logic [NUM_SLOTS-1:0] rest;
    logic [7:0]           sel_byte;
    logic                 out_ready;
    logic                 emit;
    logic                 load;

    assign out_ready = !r_out_valid || i_pop;
    assign low_bit   = r_mask & (~r_mask + NUM_SLOTS'(1));
    assign rest      = r_mask & ~low_bit;
    assign emit      = out_ready && (r_mask != '0);
    assign load      = i_job_valid && ((r_mask == '0) || (emit && (rest == '0)));
    assign o_job_pop = load;
    assign o_empty   = !r_out_valid;
    assign o_result  = r_out;

    // Byte carried by each slot of the current job.
    always_comb begin
        slot_byte[0] = r_rel_order ? (SC_CTRL | SC_BREAK)  : SC_SHIFT;
        slot_byte[1] = r_rel_order ? (SC_SHIFT | SC_BREAK) : SC_CTRL;
        slot_byte[2] = r_rel_order ? (SC_ALT | SC_BREAK)   : SC_ALT;
        slot_byte[3] = SC_EXT;
        slot_byte[4] = r_scan;
        slot_byte[5] = r_scan | SC_BREAK;
        slot_byte[6] = SC_SHIFT | SC_BREAK;
        slot_byte[7] = SC_CTRL | SC_BREAK;
        slot_byte[8] = SC_ALT | SC_BREAK;
    end

    // Pick the byte of the lowest pending slot.
    always_comb begin
        sel_byte = '0;
        for (int i = 0; i < NUM_SLOTS; i++) begin
            sel_byte = sel_byte | (low_bit[i] ? slot_byte[i] : 8'h00);
        end
    end

    // Slot mask and result register valid.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_mask      <= '0;
            r_out_valid <= 1'b0;
        end else begin
            if (load) begin
                r_mask <= i_job.slots;
            end else if (emit) begin
                r_mask <= rest;
            end
            if (emit) begin
                r_out_valid <= 1'b1;
            end else if (i_pop) begin
                r_out_valid <= 1'b0;
            end
        end
    end

    // Job payload and result byte.
    always_ff @(posedge i_clk) begin
        if (load) begin
            r_rel_order <= i_job.rel_order;
            r_scan      <= i_job.scan;
        end
        if (emit) begin
            r_out.scan_byte <= sel_byte;
            r_out.last_byte <= rest == '0;
        end
    end

endmodule

>>> rtl/modifier_scancode_emitter.sv
// Modifier scancode emitter: turns key events and modifier commands into
// keyboard scancode bytes. Depends on mse_pkg, mse_front, mse_job_queue, mse_back.
//
// Usage:
//   Input channel: an item transfers at a clock edge with push high and
//   full low. The front decodes it in that same cycle, updates the one-shot,
//   sticky and help flags, and writes a byte job into the job queue.
//   Result channel: while empty is low the oldest byte is on o_result; it
//   transfers at a clock edge with pop high. last_byte marks the final byte
//   caused by one input item. Items that cause no bytes leave no job.
//   Path: an item's job passes the job queue and the back part's slot mask
//   on its way to the result register.
//   Throughput: the back part sends one byte per cycle while jobs wait and pop
//   keeps the result register free; an item has one to nine bytes, and a key
//   event with all three modifiers and the E0 prefix has nine. full rises when
//   the job queue (JOB_DEPTH jobs) is full.
//   A receiver that holds pop low stalls the back part; the front keeps
//   taking items until the job queue fills.
//   Reset clears all flags, the job queue and the result register.
module modifier_scancode_emitter #(
    parameter int unsigned JOB_DEPTH = mse_pkg::JOB_DEPTH_DEFAULT
) (
    input  logic               i_clk,
    input  logic               i_rst_n,
    input  logic               push,
    output logic               full,
    input  mse_pkg::t_in_item  i_item,
    output logic               empty,
    input  logic               pop,
    output mse_pkg::t_out_item o_result
);
    import mse_pkg::*;

    t_job_req job_req;
    logic     accept;
    logic     job_valid;
    t_job     job_head;
    logic     job_pop;

    assign accept = push && !full;

    // Decode and flag keeping.
    mse_front u_front (
        .i_clk     (i_clk),
        .i_rst_n   (i_rst_n),
        .i_accept  (accept),
        .i_item    (i_item),
        .o_job_req (job_req)
    );

    // Job queue between the two parts.
    mse_job_queue #(
        .DEPTH (JOB_DEPTH)
    ) u_queue (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_push_req (job_req),
        .i_pop      (job_pop),
        .o_full     (full),
        .o_valid    (job_valid),
        .o_job      (job_head)
    );

    // Byte sequencer and result register.
    mse_back u_back (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_job_valid (job_valid),
        .i_job       (job_head),
        .o_job_pop   (job_pop),
        .i_pop       (pop),
        .o_empty     (empty),
        .o_result    (o_result)
    );

endmodule

>>> rtl/mse_checker.sv
// Port-level checks for the modifier scancode emitter, bound to the top
// level. Depends on mse_pkg and modifier_scancode_emitter.
module mse_checker (
    input logic               i_clk,
    input logic               i_rst_n,
    input logic               push,
    input logic               full,
    input mse_pkg::t_in_item  i_item,
    input logic               empty,
    input logic               pop,
    input mse_pkg::t_out_item o_result
);
    import mse_pkg::*;

    // Reset leaves no byte waiting and room for input.
    a_reset_clears : assert property (@(posedge i_clk)
        !i_rst_n |=> empty && !full)
        else $error("result or queue not cleared by reset");

    // A stalled result holds.
    a_stall_holds : assert property (@(posedge i_clk) disable iff (!i_rst_n)
        !empty && !pop |=> !empty && $stable(o_result))
        else $error("stalled result changed");

    // A final byte below the break range is only a sticky modifier make code.
    a_last_make : assert property (@(posedge i_clk) disable iff (!i_rst_n)
        !empty && o_result.last_byte && !o_result.scan_byte[7] |->
            o_result.scan_byte == SC_SHIFT || o_result.scan_byte == SC_CTRL
            || o_result.scan_byte == SC_ALT)
        else $error("unexpected final make code");

    // Without an input transfer the job queue cannot become full.
    a_no_full_from_idle : assert property (@(posedge i_clk) disable iff (!i_rst_n)
        $past(!full) && $past(!push) |-> !full)
        else $error("queue filled without input");

endmodule

bind modifier_scancode_emitter mse_checker u_mse_checker (.*);
